// File: sv/assert_macros.svh
// Assertion macros shared by the team queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTF_ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTF_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTF_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// File: sv/gtf_pkg.sv
// Package with the field widths, operation and status codes of the team queue.
package gtf_pkg;

	localparam int FUNC_W    = 2;
	localparam int ELEM_W    = 10;
	localparam int TEAM_IN_W = 4;
	localparam int STATUS_W  = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_MAP = 2'd0,
		FN_ENQ = 2'd1,
		FN_DEQ = 2'd2,
		FN_CLR = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE  = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [ELEM_W-1:0]   element;
	} res_t;

endpackage

// File: sv/gtf_in_if.sv
// Command channel interface of the team queue.
interface gtf_in_if;
	logic                            valid;
	logic                            ready;
	logic [gtf_pkg::FUNC_W-1:0]      func;
	logic [gtf_pkg::ELEM_W-1:0]      element;
	logic [gtf_pkg::TEAM_IN_W-1:0]   team;

	modport source (output valid, func, element, team, input ready);
	modport sink (input valid, func, element, team, output ready);
endinterface

// File: sv/gtf_out_if.sv
// Result channel interface of the team queue.
interface gtf_out_if;
	logic                            valid;
	logic                            ready;
	logic [gtf_pkg::STATUS_W-1:0]    status;
	logic [gtf_pkg::ELEM_W-1:0]      out_element;

	modport source (output valid, status, out_element, input ready);
	modport sink (input valid, status, out_element, output ready);
endinterface

// File: sv/gtf_front.sv
// Front stage: accepts commands and reduces the element id and team number.
module gtf_front #(
	parameter int ELEMENT_IDS = 1024,
	parameter int TEAMS = 16,
	parameter type cmd_t = logic
) (
	input  logic       clk,
	input  logic       arst_n,
	gtf_in_if.sink     cmd,
	input  logic       hold,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_data
);

	localparam int EW = gtf_pkg::ELEM_W;
	localparam int IW = $clog2(ELEMENT_IDS);
	localparam int TW = $clog2(TEAMS);
	localparam int SH = EW + IW + 1;
	localparam int PW = EW + SH;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(ELEMENT_IDS) - 64'd1) / 64'(ELEMENT_IDS);

	function automatic logic [TW-1:0] team_wrap(input logic [gtf_pkg::TEAM_IN_W-1:0] t);
		logic [TW-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << gtf_pkg::TEAM_IN_W); i++) begin
			if (t == gtf_pkg::TEAM_IN_W'(i)) begin
				r = TW'(i % TEAMS);
			end
		end
		return r;
	endfunction

	logic                 v_s1;
	gtf_pkg::func_t       func_s1;
	logic [EW-1:0]        elem_s1;
	logic [TW-1:0]        team_s1;
	logic [PW-1:0]        prod_s1;
	logic                 take;
	logic [EW-1:0]        quo;
	logic [EW-1:0]        quo_n;
	logic [EW-1:0]        rem;

	assign cmd.ready = !hold && (!v_s1 || push_ready);
	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= gtf_pkg::func_t'(cmd.func);
			elem_s1 <= cmd.element;
			team_s1 <= team_wrap(cmd.team);
			prod_s1 <= PW'(cmd.element) * PW'(RECIP);
		end
	end

	// The reciprocal is rounded up with enough guard bits to give the exact quotient.
	always_comb begin
		quo   = prod_s1[PW-1:SH];
		quo_n = quo * EW'(ELEMENT_IDS);
		rem   = elem_s1 - quo_n;
	end

	assign push_valid        = v_s1;
	assign push_data.func    = func_s1;
	assign push_data.element = elem_s1;
	assign push_data.idx     = IW'(rem);
	assign push_data.team    = team_s1;

endmodule

// File: sv/gtf_queue.sv
// Two-entry queue between the front stage and the sequencer.
module gtf_queue #(
	parameter type item_t = logic
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output item_t  out_data
);

	localparam int DEPTH = 2;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

// File: sv/gtf_back.sv
// Sequencer: membership table, per-team FIFOs, team-order ring and result register.
module gtf_back #(
	parameter int ELEMENT_IDS = 1024,
	parameter int TEAMS = 16,
	parameter int TEAM_DEPTH = 16,
	parameter type cmd_t = logic
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  cmd_t                          q_data,
	gtf_out_if.source                     rsp,
	output logic                          init_busy,
	output logic [$clog2(TEAMS+1)-1:0]    ring_fill
);

	localparam int EW     = gtf_pkg::ELEM_W;
	localparam int IW     = $clog2(ELEMENT_IDS);
	localparam int TW     = $clog2(TEAMS);
	localparam int HW     = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
	localparam int FW     = $clog2(TEAM_DEPTH + 1);
	localparam int OFW    = $clog2(TEAMS + 1);
	localparam int SDEPTH = TEAMS * TEAM_DEPTH;
	localparam int AW     = $clog2(SDEPTH);
	localparam int SWEEP  = (ELEMENT_IDS > TEAMS) ? ELEMENT_IDS : TEAMS;
	localparam int SW     = $clog2(SWEEP);

	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_LOOK = 7'b0000100,
		S_TEAM = 7'b0001000,
		S_SLOT = 7'b0010000,
		S_CLR  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	cmd_t               cmd_q;
	logic [TW-1:0]      team_q;
	logic [SW-1:0]      sweep_q;
	logic [TW-1:0]      oh_q;
	logic [OFW-1:0]     of_q;
	gtf_pkg::res_t      res_q;
	gtf_pkg::res_t      out_q;
	logic               out_v_q;

	logic [TW-1:0]      member_mem [ELEMENT_IDS];
	logic [TW-1:0]      ring_mem [TEAMS];
	logic [HW-1:0]      head_mem [TEAMS];
	logic [FW-1:0]      fill_mem [TEAMS];
	logic [EW-1:0]      slot_mem [SDEPTH];

	logic [TW-1:0]      member_rd;
	logic [TW-1:0]      ring_rd;
	logic [HW-1:0]      head_rd;
	logic [FW-1:0]      fill_rd;
	logic [EW-1:0]      slot_rd;

	logic               fin;
	logic               out_free;
	logic               load;
	gtf_pkg::res_t      res_d;
	logic               pop;
	logic               clr_start;
	logic               ring_push;
	logic               ring_pop;
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	logic [TW-1:0]      mem_wd;
	logic               tw_we;
	logic [TW-1:0]      tw_wa;
	logic [HW-1:0]      head_wd;
	logic [FW-1:0]      fill_wd;
	logic               slot_we;
	logic [AW-1:0]      slot_base;
	logic [AW-1:0]      slot_wa;
	logic [AW-1:0]      slot_ra;
	logic [TW-1:0]      team_look;
	logic [OFW:0]       ring_sum;
	logic [TW-1:0]      ring_pos;
	logic [TW:0]        oh_inc;
	logic [TW-1:0]      oh_nx;
	logic [FW:0]        tail_sum;
	logic [HW-1:0]      tail;
	logic [HW:0]        head_inc;
	logic [HW-1:0]      head_nx;
	logic               full;

	assign q_ready   = state_q == S_IDLE;
	assign init_busy = state_q == S_INIT;
	assign ring_fill = of_q;
	assign out_free  = !out_v_q || rsp.ready;

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_q.status;
	assign rsp.out_element = out_q.element;

	always_comb begin
		team_look = (cmd_q.func == gtf_pkg::FN_ENQ) ? member_rd : ring_rd;
		ring_sum  = (OFW+1)'(oh_q) + (OFW+1)'(of_q);
		ring_pos  = (ring_sum >= (OFW+1)'(TEAMS)) ? TW'(ring_sum - (OFW+1)'(TEAMS))
			: TW'(ring_sum);
		oh_inc    = (TW+1)'(oh_q) + (TW+1)'(1);
		oh_nx     = (oh_inc >= (TW+1)'(TEAMS)) ? '0 : TW'(oh_inc);
		tail_sum  = (FW+1)'(head_rd) + (FW+1)'(fill_rd);
		tail      = (tail_sum >= (FW+1)'(TEAM_DEPTH)) ? HW'(tail_sum - (FW+1)'(TEAM_DEPTH))
			: HW'(tail_sum);
		head_inc  = (HW+1)'(head_rd) + (HW+1)'(1);
		head_nx   = (head_inc >= (HW+1)'(TEAM_DEPTH)) ? '0 : HW'(head_inc);
		full      = fill_rd == FW'(TEAM_DEPTH);
		slot_base = AW'(team_q) * AW'(TEAM_DEPTH);
		slot_wa   = slot_base + AW'(tail);
		slot_ra   = slot_base + AW'(head_rd);
	end

	always_comb begin
		state_d       = state_q;
		fin           = 1'b0;
		res_d.status  = gtf_pkg::ST_NONE;
		res_d.element = '0;
		pop           = 1'b0;
		clr_start     = 1'b0;
		ring_push     = 1'b0;
		ring_pop      = 1'b0;
		mem_we        = 1'b0;
		mem_wa        = sweep_q[IW-1:0];
		mem_wd        = '0;
		tw_we         = 1'b0;
		tw_wa         = sweep_q[TW-1:0];
		head_wd       = '0;
		fill_wd       = '0;
		slot_we       = 1'b0;
		case (state_q)
			S_INIT: begin
				mem_we = int'(sweep_q) < ELEMENT_IDS;
				tw_we  = int'(sweep_q) < TEAMS;
				if (int'(sweep_q) == SWEEP - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_data.func)
						gtf_pkg::FN_MAP: begin
							mem_we = 1'b1;
							mem_wa = q_data.idx;
							mem_wd = q_data.team;
							fin    = 1'b1;
						end
						gtf_pkg::FN_ENQ: begin
							state_d = S_LOOK;
						end
						gtf_pkg::FN_DEQ: begin
							if (of_q == '0) begin
								fin          = 1'b1;
								res_d.status = gtf_pkg::ST_EMPTY;
							end else begin
								state_d = S_LOOK;
							end
						end
						default: begin
							clr_start = 1'b1;
							state_d   = S_CLR;
						end
					endcase
				end
			end
			S_LOOK: begin
				state_d = S_TEAM;
			end
			S_TEAM: begin
				if (cmd_q.func == gtf_pkg::FN_ENQ) begin
					fin = 1'b1;
					if (full) begin
						res_d.status = gtf_pkg::ST_FULL;
					end else begin
						slot_we   = 1'b1;
						tw_we     = 1'b1;
						tw_wa     = team_q;
						head_wd   = head_rd;
						fill_wd   = fill_rd + FW'(1);
						ring_push = (fill_rd == '0) && (int'(of_q) < TEAMS);
					end
				end else if (fill_rd == '0) begin
					fin          = 1'b1;
					res_d.status = gtf_pkg::ST_EMPTY;
				end else begin
					tw_we    = 1'b1;
					tw_wa    = team_q;
					head_wd  = head_nx;
					fill_wd  = fill_rd - FW'(1);
					ring_pop = fill_rd == FW'(1);
					state_d  = S_SLOT;
				end
			end
			S_SLOT: begin
				fin           = 1'b1;
				res_d.status  = gtf_pkg::ST_DEQ;
				res_d.element = slot_rd;
			end
			S_CLR: begin
				tw_we = 1'b1;
				if (int'(sweep_q) == TEAMS - 1) begin
					fin = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_DONE;
		end
	end

	assign load = out_free && (fin || (state_q == S_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			oh_q    <= '0;
			of_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_start) begin
				sweep_q <= '0;
				oh_q    <= '0;
				of_q    <= '0;
			end else begin
				if (state_q == S_INIT || state_q == S_CLR) begin
					sweep_q <= sweep_q + SW'(1);
				end
				if (ring_push) begin
					of_q <= of_q + OFW'(1);
				end
				if (ring_pop) begin
					oh_q <= oh_nx;
					of_q <= of_q - OFW'(1);
				end
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
		end
		if (state_q == S_LOOK) begin
			team_q <= team_look;
		end
		if (fin) begin
			res_q <= res_d;
		end
		if (load) begin
			out_q <= (state_q == S_DONE) ? res_q : res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			member_mem[mem_wa] <= mem_wd;
		end
		member_rd <= member_mem[q_data.idx];
	end

	always_ff @(posedge clk) begin
		if (ring_push) begin
			ring_mem[ring_pos] <= team_q;
		end
		ring_rd <= ring_mem[oh_q];
	end

	always_ff @(posedge clk) begin
		if (tw_we) begin
			head_mem[tw_wa] <= head_wd;
			fill_mem[tw_wa] <= fill_wd;
		end
		head_rd <= head_mem[team_look];
		fill_rd <= fill_mem[team_look];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= cmd_q.element;
		end
		slot_rd <= slot_mem[slot_ra];
	end

endmodule

// File: sv/grouped_team_fifo.sv
// Top level of the team queue: front stage, command queue and sequencer.
//
// Commands arrive on cmd (func, element, team) and every command yields exactly one
// transaction on rsp (status, out_element), in command order. A command passes the
// front register and the two-entry queue, then the sequencer handles it: a map or a
// dequeue on an empty ring finishes in the idle state, an enqueue passes the look and
// team states, a dequeue the look, team and slot states, and a clear sweeps the team
// pointers in the clear state. The chain of memory reads (membership table or ring,
// then team pointers, then slot memory) sets these steps; the sequencer takes a new
// command only when it is back in its idle state.
// After reset the sequencer clears the membership table and the team pointers in a
// pass over max(ELEMENT_IDS, TEAMS) entries, and cmd.ready stays low during it. A
// result that rsp does not take stays in the output register; the sequencer then
// holds its next result, the queue and the front register fill, and cmd.ready drops.
`include "assert_macros.svh"

module grouped_team_fifo #(
	parameter int ELEMENT_IDS = 1024,
	parameter int TEAMS = 16,
	parameter int TEAM_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	gtf_in_if.sink      cmd,
	gtf_out_if.source   rsp
);

	localparam int IW  = $clog2(ELEMENT_IDS);
	localparam int TW  = $clog2(TEAMS);
	localparam int OFW = $clog2(TEAMS + 1);

	typedef struct packed {
		gtf_pkg::func_t                func;
		logic [gtf_pkg::ELEM_W-1:0]    element;
		logic [IW-1:0]                 idx;
		logic [TW-1:0]                 team;
	} cmd_t;

	logic            init_busy;
	logic            f_valid;
	logic            f_ready;
	cmd_t            f_data;
	logic            b_valid;
	logic            b_ready;
	cmd_t            b_data;
	logic [OFW-1:0]  ring_fill;

	gtf_front #(
		.ELEMENT_IDS (ELEMENT_IDS),
		.TEAMS       (TEAMS),
		.cmd_t       (cmd_t)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.hold       (init_busy),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	gtf_queue #(
		.item_t (cmd_t)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	gtf_back #(
		.ELEMENT_IDS (ELEMENT_IDS),
		.TEAMS       (TEAMS),
		.TEAM_DEPTH  (TEAM_DEPTH),
		.cmd_t       (cmd_t)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_data    (b_data),
		.rsp       (rsp),
		.init_busy (init_busy),
		.ring_fill (ring_fill)
	);

	`GTF_ASSERT(a_quiet_in_init, clk, arst_n, init_busy |-> !rsp.valid, "result during clearing pass")
	`GTF_ASSERT(a_elem_zero, clk, arst_n, (rsp.valid && rsp.status != gtf_pkg::ST_DEQ) |-> (rsp.out_element == '0), "element set without dequeue")
	`GTF_ASSERT(a_ring_bound, clk, arst_n, ring_fill <= OFW'(TEAMS), "team ring overfilled")
	`GTF_ASSERT_ANY(a_quiet_in_reset, clk, !arst_n |-> !rsp.valid, "result while in reset")

endmodule
